// ===== design/kts_pkg.sv =====
// Shared types and constants for the keyword token scanner.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package kts_pkg;

    localparam int MAX_IDENT_CHARS_DEF = 8;
    localparam int NUMBER_BITS_DEF     = 32;

    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 5;
    localparam int VALUE_W = 32;
    localparam int TEXT_W  = 64;
    localparam int LEN_W   = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_END    = 5'd0,
        KIND_BEGIN  = 5'd1,
        KIND_IF     = 5'd2,
        KIND_THEN   = 5'd3,
        KIND_WHILE  = 5'd4,
        KIND_DO     = 5'd5,
        KIND_ENDKW  = 5'd6,
        KIND_IDENT  = 5'd7,
        KIND_NUMBER = 5'd8,
        KIND_PLUS   = 5'd9,
        KIND_MINUS  = 5'd10,
        KIND_STAR   = 5'd11,
        KIND_SLASH  = 5'd12,
        KIND_COLON  = 5'd13,
        KIND_ASSIGN = 5'd14,
        KIND_LT     = 5'd15,
        KIND_NE     = 5'd16,
        KIND_LE     = 5'd17,
        KIND_GT     = 5'd18,
        KIND_GE     = 5'd19,
        KIND_EQ     = 5'd20,
        KIND_SEMI   = 5'd21,
        KIND_LPAREN = 5'd22,
        KIND_RPAREN = 5'd23,
        KIND_ERROR  = 5'd24
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [VALUE_W-1:0]  number_value;
        logic [TEXT_W-1:0]   ident_text;
        logic [LEN_W-1:0]    ident_length;
        logic                overflow_flag;
        logic                last_of_run;
    } t_token;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2a;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2f;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3a;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
    localparam logic [CHAR_W-1:0] CH_LT     = 8'h3c;
    localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3d;
    localparam logic [CHAR_W-1:0] CH_GT     = 8'h3e;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;

    // Keywords packed first character in the low byte, zero padded
    localparam int NUM_KEYWORDS = 6;
    localparam logic [TEXT_W-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        64'h0000_006e_6967_6562,   // begin
        64'h0000_0000_0000_6669,   // if
        64'h0000_0000_6e65_6874,   // then
        64'h0000_0065_6c69_6877,   // while
        64'h0000_0000_0000_6f64,   // do
        64'h0000_0000_0064_6e65    // end
    };
    localparam logic [LEN_W-1:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd5, 4'd2, 4'd4, 4'd5, 4'd2, 4'd3
    };

endpackage

`default_nettype wire

// ===== design/kts_char_if.sv =====
// Character input channel: valid/ready handshake carrying one source byte.
// Depends on kts_pkg for the character width.
`timescale 1ns / 1ps
`default_nettype none

interface kts_char_if;
    logic                       valid;
    logic                       ready;
    logic [kts_pkg::CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

// ===== design/kts_token_if.sv =====
// Token output channel: valid/ready handshake carrying one scanned token.
// Depends on kts_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface kts_token_if;
    logic                        valid;
    logic                        ready;
    logic [kts_pkg::KIND_W-1:0]  token_kind;
    logic [kts_pkg::VALUE_W-1:0] number_value;
    logic [kts_pkg::TEXT_W-1:0]  ident_text;
    logic [kts_pkg::LEN_W-1:0]   ident_length;
    logic                        overflow_flag;
    logic                        last_of_run;

    modport source (output valid, output token_kind, output number_value,
                    output ident_text, output ident_length, output overflow_flag,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input number_value,
                    input ident_text, input ident_length, input overflow_flag,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== design/keyword_token_scanner.sv =====
// Keyword token scanner top level: scan state, token logic and output queue.
// Depends on kts_pkg, kts_char_if and kts_token_if.
`timescale 1ns / 1ps
`default_nettype none

// The scanner takes one source character per transfer on i_char and emits
// tokens on o_tok: the six keywords, identifiers, decimal numbers, the
// single and paired operators, an end token for '#' and an error token for
// any byte it does not know. A character that closes a pending token (a
// number, an identifier or a lone '<', '>' or ':') first emits that token
// and is then scanned on its own, so one character can yield two tokens;
// last_of_run marks the final token a character produced. Identifiers keep
// at most MAX_IDENT_CHARS characters and numbers saturate at
// 2^NUMBER_BITS-1; either case sets overflow_flag, and a truncated name is
// never reported as a keyword. Rate: one character per clock while
// i_char.ready is high, which needs at most one token in the three-entry
// token queue; the scan is a single pass of logic from the state registers
// into that queue, which drains one token per clock while o_tok.ready is
// high. Tokens reach o_tok in the cycle after the transfer at the earliest.
module keyword_token_scanner #(
    parameter int MAX_IDENT_CHARS = kts_pkg::MAX_IDENT_CHARS_DEF,
    parameter int NUMBER_BITS     = kts_pkg::NUMBER_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    kts_char_if.sink     i_char,
    kts_token_if.source  o_tok
);

    localparam int BUF_W   = 8 * MAX_IDENT_CHARS;
    localparam int CNT_W   = $clog2(MAX_IDENT_CHARS + 1);
    localparam int WIDE_W  = NUMBER_BITS + 4;
    localparam int QDEPTH  = 3;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_NUM   = 3'd1,
        S_IDENT = 3'd2,
        S_LT    = 3'd3,
        S_GT    = 3'd4,
        S_COLON = 3'd5
    } t_state;

    // Scan state
    t_state                   r_state,  n_state;
    logic [NUMBER_BITS-1:0]   r_acc,    n_acc;
    logic [BUF_W-1:0]         r_buf,    n_buf;
    logic [CNT_W-1:0]         r_cnt,    n_cnt;
    logic                     r_ovf,    n_ovf;

    // Token queue
    kts_pkg::t_token          r_q [QDEPTH];
    logic [1:0]               r_rd,     n_rd;
    logic [1:0]               r_wr,     n_wr;
    logic [1:0]               r_qcnt,   n_qcnt;

    logic                     in_xfer;
    logic                     out_xfer;
    logic [kts_pkg::CHAR_W-1:0] c;
    logic                     is_dig;
    logic                     is_let;
    logic [3:0]               digit;
    logic [WIDE_W-1:0]        acc_next;
    kts_pkg::t_kind           ident_kind;
    kts_pkg::t_token          tok_end;   // token closed by this character
    kts_pkg::t_token          tok_own;   // token of the character itself
    logic                     ended;
    logic                     own;
    logic [1:0]               push;
    kts_pkg::t_token          head;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        return (p == 2'(QDEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    assign c        = i_char.char_in;
    assign in_xfer  = i_char.valid && i_char.ready;
    assign out_xfer = o_tok.valid && o_tok.ready;

    // Room for two tokens whatever the consumer does this cycle
    assign i_char.ready = (r_qcnt <= 2'd1);

    assign is_dig = c inside {[kts_pkg::CH_ZERO:kts_pkg::CH_NINE]};
    assign is_let = c inside {[kts_pkg::CH_LOWER_A:kts_pkg::CH_LOWER_Z],
                              [kts_pkg::CH_UPPER_A:kts_pkg::CH_UPPER_Z]};
    assign digit  = c[3:0];

    // acc * 10 + digit, in a width that cannot wrap
    assign acc_next = (WIDE_W'(r_acc) << 3) + (WIDE_W'(r_acc) << 1) + WIDE_W'(digit);

    // Keyword lookup on the pending identifier
    always_comb begin
        ident_kind = kts_pkg::KIND_IDENT;
        if (!r_ovf) begin
            for (int i = 0; i < kts_pkg::NUM_KEYWORDS; i++) begin
                if (kts_pkg::TEXT_W'(r_buf) == kts_pkg::KW_TEXT[i] &&
                    kts_pkg::LEN_W'(r_cnt) == kts_pkg::KW_LEN[i]) begin
                    ident_kind = kts_pkg::t_kind'(kts_pkg::KIND_W'(i + 1));
                end
            end
        end
    end

    // Scan one character
    always_comb begin
        logic scan_idle;
        n_state   = r_state;
        n_acc     = r_acc;
        n_buf     = r_buf;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        ended     = 1'b0;
        own       = 1'b0;
        scan_idle = 1'b1;
        tok_end   = '0;
        tok_own   = '0;

        case (r_state)
            S_NUM: begin
                if (is_dig) begin
                    scan_idle = 1'b0;
                    if (acc_next[WIDE_W-1:NUMBER_BITS] != '0) begin
                        n_acc = '1;
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = acc_next[NUMBER_BITS-1:0];
                    end
                end else begin
                    ended                = 1'b1;
                    tok_end.kind         = kts_pkg::KIND_NUMBER;
                    tok_end.number_value = kts_pkg::VALUE_W'(r_acc);
                    tok_end.overflow_flag = r_ovf;
                end
            end
            S_IDENT: begin
                if (is_let || is_dig) begin
                    scan_idle = 1'b0;
                    if (r_cnt < CNT_W'(MAX_IDENT_CHARS)) begin
                        for (int i = 0; i < MAX_IDENT_CHARS; i++) begin
                            if (r_cnt == CNT_W'(i)) begin
                                n_buf[8*i +: 8] = c;
                            end
                        end
                        n_cnt = r_cnt + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else begin
                    ended                 = 1'b1;
                    tok_end.kind          = ident_kind;
                    tok_end.ident_text    = kts_pkg::TEXT_W'(r_buf);
                    tok_end.ident_length  = kts_pkg::LEN_W'(r_cnt);
                    tok_end.overflow_flag = r_ovf;
                end
            end
            S_LT: begin
                ended = 1'b1;
                if (c == kts_pkg::CH_GT || c == kts_pkg::CH_EQ) begin
                    scan_idle    = 1'b0;
                    n_state      = S_IDLE;
                    tok_end.kind = (c == kts_pkg::CH_GT) ? kts_pkg::KIND_NE
                                                         : kts_pkg::KIND_LE;
                end else begin
                    tok_end.kind = kts_pkg::KIND_LT;
                end
            end
            S_GT: begin
                ended = 1'b1;
                if (c == kts_pkg::CH_EQ) begin
                    scan_idle    = 1'b0;
                    n_state      = S_IDLE;
                    tok_end.kind = kts_pkg::KIND_GE;
                end else begin
                    tok_end.kind = kts_pkg::KIND_GT;
                end
            end
            S_COLON: begin
                ended = 1'b1;
                if (c == kts_pkg::CH_EQ) begin
                    scan_idle    = 1'b0;
                    n_state      = S_IDLE;
                    tok_end.kind = kts_pkg::KIND_ASSIGN;
                end else begin
                    tok_end.kind = kts_pkg::KIND_COLON;
                end
            end
            default: begin
            end
        endcase

        // Start over from idle with the same character
        if (scan_idle) begin
            n_state = S_IDLE;
            n_acc   = '0;
            n_buf   = '0;
            n_cnt   = '0;
            n_ovf   = 1'b0;
            if (is_dig) begin
                n_state = S_NUM;
                n_acc   = NUMBER_BITS'(digit);
            end else if (is_let) begin
                n_state     = S_IDENT;
                n_buf[7:0]  = c;
                n_cnt       = CNT_W'(1);
            end else begin
                own = 1'b1;
                case (c)
                    kts_pkg::CH_SPACE:  own = 1'b0;
                    kts_pkg::CH_LT:     begin own = 1'b0; n_state = S_LT;    end
                    kts_pkg::CH_GT:     begin own = 1'b0; n_state = S_GT;    end
                    kts_pkg::CH_COLON:  begin own = 1'b0; n_state = S_COLON; end
                    kts_pkg::CH_PLUS:   tok_own.kind = kts_pkg::KIND_PLUS;
                    kts_pkg::CH_MINUS:  tok_own.kind = kts_pkg::KIND_MINUS;
                    kts_pkg::CH_STAR:   tok_own.kind = kts_pkg::KIND_STAR;
                    kts_pkg::CH_SLASH:  tok_own.kind = kts_pkg::KIND_SLASH;
                    kts_pkg::CH_EQ:     tok_own.kind = kts_pkg::KIND_EQ;
                    kts_pkg::CH_SEMI:   tok_own.kind = kts_pkg::KIND_SEMI;
                    kts_pkg::CH_LPAREN: tok_own.kind = kts_pkg::KIND_LPAREN;
                    kts_pkg::CH_RPAREN: tok_own.kind = kts_pkg::KIND_RPAREN;
                    kts_pkg::CH_HASH:   tok_own.kind = kts_pkg::KIND_END;
                    default:            tok_own.kind = kts_pkg::KIND_ERROR;
                endcase
            end
        end

        tok_own.last_of_run = 1'b1;
        tok_end.last_of_run = !own;
    end

    assign push = in_xfer ? ({1'b0, ended} + {1'b0, own}) : 2'd0;

    // Queue pointers and fill level
    always_comb begin
        n_wr = r_wr;
        if (push == 2'd1) begin
            n_wr = ptr_inc(r_wr);
        end else if (push == 2'd2) begin
            n_wr = ptr_inc(ptr_inc(r_wr));
        end
        n_rd   = out_xfer ? ptr_inc(r_rd) : r_rd;
        n_qcnt = r_qcnt + push - {1'b0, out_xfer};
    end

    // Control and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_buf   <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_qcnt  <= '0;
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
                r_acc   <= n_acc;
                r_buf   <= n_buf;
                r_cnt   <= n_cnt;
                r_ovf   <= n_ovf;
            end
            r_rd   <= n_rd;
            r_wr   <= n_wr;
            r_qcnt <= n_qcnt;
        end
    end

    // Queue payload: closed token first, then the character's own token
    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_q[r_wr] <= ended ? tok_end : tok_own;
        end
        if (push == 2'd2) begin
            r_q[ptr_inc(r_wr)] <= tok_own;
        end
    end

    assign head = r_q[r_rd];

    assign o_tok.valid         = (r_qcnt != 2'd0);
    assign o_tok.token_kind    = head.kind;
    assign o_tok.number_value  = head.number_value;
    assign o_tok.ident_text    = head.ident_text;
    assign o_tok.ident_length  = head.ident_length;
    assign o_tok.overflow_flag = head.overflow_flag;
    assign o_tok.last_of_run   = head.last_of_run;

    // Idle means nothing pending
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_acc == '0 && r_cnt == '0 && !r_ovf))
        else $error("pending buffers not clear while idle");

    // Overflow only belongs to a number or identifier in progress
    a_ovf_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_state == S_NUM || r_state == S_IDENT))
        else $error("overflow set outside number or identifier");

    // Identifier count never passes the buffer size
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CNT_W'(MAX_IDENT_CHARS)))
        else $error("identifier count beyond buffer");

    // A number token carries no identifier text
    a_num_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && o_tok.token_kind == kts_pkg::KIND_NUMBER)
        |-> (o_tok.ident_text == '0 && o_tok.ident_length == '0))
        else $error("number token with identifier text");

endmodule

`default_nettype wire
